// ----- design/swtmr_pkg.sv -----
`default_nettype none

package swtmr_pkg;

  // Operation codes of a request.
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_READ_PLAIN  = 3'd1,
    OP_CLEAR_PLAIN = 3'd2,
    OP_READ_GATED  = 3'd3,
    OP_STOP        = 3'd4,
    OP_START       = 3'd5,
    OP_PAUSE       = 3'd6,
    OP_CONTINUE    = 3'd7
  } op_t;

  // Modes of a gated timer.
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_t;

  localparam int COUNT_W = 32;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 3;

  typedef struct packed {
    op_t                  operation;
    logic [INDEX_W-1:0]   timer_index;
    logic [COUNT_W-1:0]   tick_count;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   timer_value;
    logic [MODE_W-1:0]    timer_mode;
  } rsp_t;

endpackage

`default_nettype wire

// ----- design/software_timer_bank.sv -----
// A read, clear or gated-control request reads its entry in the access state, and its result
// and strobe are registered from there; a tick request gives its result once the walk has
// written back the last entry. A new request is taken only while busy is low; a tick holds
// busy while it walks the single read port of each counter memory one entry a cycle.
// Reset clears per-entry valid bits at once, so every counter reads zero and stopped.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module software_timer_bank #(
  parameter int PLAIN_TIMERS = 8,
  parameter int GATED_TIMERS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire swtmr_pkg::req_t  request,
  output logic                  done,
  output swtmr_pkg::rsp_t       result
);

  localparam int MAXT   = (PLAIN_TIMERS > GATED_TIMERS) ? PLAIN_TIMERS : GATED_TIMERS;
  localparam int PW     = (PLAIN_TIMERS > 1) ? $clog2(PLAIN_TIMERS) : 1;
  localparam int GW     = (GATED_TIMERS > 1) ? $clog2(GATED_TIMERS) : 1;
  localparam int WALK_W = $clog2(MAXT + 1);
  localparam int SEL_W  = (WALK_W > swtmr_pkg::INDEX_W) ? WALK_W : swtmr_pkg::INDEX_W;
  localparam int CW     = swtmr_pkg::COUNT_W;
  localparam int GD_W   = swtmr_pkg::COUNT_W + swtmr_pkg::MODE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ACCESS
  } state_t;

  state_t            state;
  state_t            state_next;
  swtmr_pkg::req_t   req_q;
  logic [WALK_W-1:0] walk_cnt;
  logic [WALK_W-1:0] walk_cnt_next;
  logic              rd_pend;
  logic              rd_pend_next;
  logic [SEL_W-1:0]  rd_addr;
  logic [SEL_W-1:0]  rd_sel;
  logic              done_next;
  swtmr_pkg::rsp_t   result_next;

  logic [PLAIN_TIMERS-1:0] plain_valid;
  logic [GATED_TIMERS-1:0] gated_valid;

  // Memory ports.
  logic            p_we;
  logic [CW-1:0]   p_wdata;
  logic [CW-1:0]   p_rdata;
  logic            g_we;
  logic [GD_W-1:0] g_wdata;
  logic [GD_W-1:0] g_rdata;

  // Entry values as read, with never-written entries taken as reset values.
  logic [CW-1:0]     p_cur;
  logic [CW-1:0]     g_count;
  swtmr_pkg::mode_t  g_mode;
  logic              p_in_range;
  logic              g_in_range;

  swtmr_ram #(.WIDTH(CW), .DEPTH(PLAIN_TIMERS)) u_plain_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (rd_addr[PW-1:0]),
    .wdata (p_wdata),
    .raddr (rd_sel[PW-1:0]),
    .rdata (p_rdata)
  );

  swtmr_ram #(.WIDTH(GD_W), .DEPTH(GATED_TIMERS)) u_gated_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (rd_addr[GW-1:0]),
    .wdata (g_wdata),
    .raddr (rd_sel[GW-1:0]),
    .rdata (g_rdata)
  );

  assign busy = (state != S_IDLE);

  // Read address: the request index when idle, the walk counter during a tick.
  assign rd_sel = (state == S_WALK) ? SEL_W'(walk_cnt) : SEL_W'(request.timer_index);

  assign p_in_range = (rd_addr < SEL_W'(PLAIN_TIMERS));
  assign g_in_range = (rd_addr < SEL_W'(GATED_TIMERS));

  always_comb begin
    p_cur   = '0;
    g_count = '0;
    g_mode  = swtmr_pkg::MODE_STOPPED;
    if (p_in_range && plain_valid[rd_addr[PW-1:0]]) begin
      p_cur = p_rdata;
    end
    if (g_in_range && gated_valid[rd_addr[GW-1:0]]) begin
      g_count = g_rdata[CW-1:0];
      g_mode  = swtmr_pkg::mode_t'(g_rdata[GD_W-1:CW]);
    end
  end

  // Sequencing, read-modify-write and result formation.
  always_comb begin
    logic [CW-1:0]    new_count;
    swtmr_pkg::mode_t new_mode;

    state_next    = state;
    walk_cnt_next = walk_cnt;
    rd_pend_next  = 1'b0;
    done_next     = 1'b0;
    result_next   = result;
    p_we          = 1'b0;
    p_wdata       = '0;
    g_we          = 1'b0;
    g_wdata       = '0;
    new_count     = g_count;
    new_mode      = g_mode;

    case (state)
      S_IDLE: begin
        if (start) begin
          walk_cnt_next = '0;
          if (request.operation == swtmr_pkg::OP_TICK) begin
            state_next = S_WALK;
          end else begin
            rd_pend_next = 1'b1;
            state_next   = S_ACCESS;
          end
        end
      end

      S_WALK: begin
        // Write back the entry read last cycle.
        if (rd_pend) begin
          p_we    = p_in_range;
          p_wdata = p_cur + req_q.tick_count;
          g_we    = g_in_range && (g_mode == swtmr_pkg::MODE_RUNNING);
          g_wdata = {g_mode, g_count + req_q.tick_count};
        end
        // Issue the next read while entries remain.
        if (walk_cnt < WALK_W'(MAXT)) begin
          rd_pend_next  = 1'b1;
          walk_cnt_next = walk_cnt + 1'b1;
        end else if (!rd_pend || walk_cnt == WALK_W'(MAXT)) begin
          done_next   = 1'b1;
          result_next = '0;
          state_next  = S_IDLE;
        end
      end

      S_ACCESS: begin
        result_next = '0;
        case (req_q.operation)
          swtmr_pkg::OP_READ_PLAIN: begin
            result_next.timer_value = p_cur;
          end
          swtmr_pkg::OP_CLEAR_PLAIN: begin
            p_we = p_in_range;
          end
          swtmr_pkg::OP_TICK: begin
            result_next = '0;
          end
          default: begin
            // Gated timer request.
            case (req_q.operation)
              swtmr_pkg::OP_STOP: begin
                new_mode = swtmr_pkg::MODE_STOPPED;
              end
              swtmr_pkg::OP_START: begin
                if (g_mode == swtmr_pkg::MODE_STOPPED) begin
                  new_count = '0;
                  new_mode  = swtmr_pkg::MODE_RUNNING;
                end
              end
              swtmr_pkg::OP_PAUSE: begin
                if (g_mode == swtmr_pkg::MODE_RUNNING) begin
                  new_mode = swtmr_pkg::MODE_PAUSED;
                end
              end
              swtmr_pkg::OP_CONTINUE: begin
                if (g_mode == swtmr_pkg::MODE_PAUSED) begin
                  new_mode = swtmr_pkg::MODE_RUNNING;
                end
              end
              default: begin
                new_mode = g_mode;
              end
            endcase
            g_we    = g_in_range && (req_q.operation != swtmr_pkg::OP_READ_GATED);
            g_wdata = {new_mode, new_count};
            if (g_in_range) begin
              result_next.timer_value = new_count;
              result_next.timer_mode  = new_mode;
            end
          end
        endcase
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, valid bits, registered result and request payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_pend     <= 1'b0;
      done        <= 1'b0;
      walk_cnt    <= '0;
      plain_valid <= '0;
      gated_valid <= '0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_pend_next;
      done     <= done_next;
      walk_cnt <= walk_cnt_next;
      if (p_we) begin
        plain_valid[rd_addr[PW-1:0]] <= 1'b1;
      end
      if (g_we) begin
        gated_valid[rd_addr[GW-1:0]] <= 1'b1;
      end
    end
    result  <= result_next;
    rd_addr <= rd_sel;
    if (start && !busy) begin
      req_q <= request;
    end
  end

endmodule

`default_nettype wire

// ----- design/swtmr_ram.sv -----
`default_nettype none

module swtmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
